// ----- hw/rtl/idb_pkg.sv -----
`default_nettype none

package idb_pkg;

	typedef struct packed {
		logic        operation;
		logic [3:0]  register_bank;
		logic [5:0]  register_index;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        access_error;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic access;
		logic finish;
	} idb_cmd_t;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [3:0] BANK_CTRL       = 4'd0;
	localparam logic [3:0] BANK_SET_ENABLE = 4'd1;
	localparam logic [3:0] BANK_CLR_ENABLE = 4'd2;
	localparam logic [3:0] BANK_SET_PEND   = 4'd3;
	localparam logic [3:0] BANK_CLR_PEND   = 4'd4;
	localparam logic [3:0] BANK_SET_ACTIVE = 4'd5;
	localparam logic [3:0] BANK_CLR_ACTIVE = 4'd6;
	localparam logic [3:0] BANK_PRIORITY   = 4'd7;
	localparam logic [3:0] BANK_TARGETS    = 4'd8;
	localparam logic [3:0] BANK_TRIGGER    = 4'd9;
	localparam logic [3:0] BANK_TYPE       = 4'd10;

	localparam logic [31:0] EDGE_PATTERN = 32'hAAAA_AAAA;

endpackage

`default_nettype wire

// ----- hw/rtl/idb_ctrl.sv -----
`default_nettype none

module idb_ctrl
	import idb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output idb_cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_ACCESS = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       rsp_valid_q;

	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && req_valid;
		cmd.access  = (state_q == ST_ACCESS);
		cmd.finish  = (state_q == ST_FINISH) && (!rsp_valid_q || rsp_ready);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.capture) begin
					state_d = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (cmd.finish) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

// ----- hw/rtl/idb_datapath.sv -----
`default_nettype none

module idb_datapath
	import idb_pkg::*;
#(
	parameter int unsigned NUM_IRQ = 256,
	parameter int unsigned NUM_CPU = 8
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire idb_cmd_t cmd,
	input  wire req_t     req,
	output rsp_t          rsp
);

	function automatic logic [31:0] low_mask(input int unsigned n);
		logic [63:0] m;
		m = (64'd1 << n) - 64'd1;
		return m[31:0];
	endfunction

	localparam int unsigned BIT_WORDS  = (NUM_IRQ + 31) / 32;
	localparam int unsigned BYTE_WORDS = (NUM_IRQ + 3) / 4;
	localparam int unsigned CFG_WORDS  = (NUM_IRQ + 15) / 16;
	localparam int unsigned BYTE_DEPTH = (BYTE_WORDS > 64) ? 64 : BYTE_WORDS;

	localparam int unsigned BIT_AW  = (BIT_WORDS > 1) ? $clog2(BIT_WORDS) : 1;
	localparam int unsigned BYTE_AW = (BYTE_DEPTH > 1) ? $clog2(BYTE_DEPTH) : 1;
	localparam int unsigned CFG_AW  = (CFG_WORDS > 1) ? $clog2(CFG_WORDS) : 1;

	localparam logic [31:0] BIT_LAST_MASK  = low_mask(NUM_IRQ - (BIT_WORDS - 1) * 32);
	localparam logic [31:0] BYTE_LAST_MASK = low_mask((NUM_IRQ - (BYTE_WORDS - 1) * 4) * 8);
	localparam logic [31:0] CFG_LAST_MASK  = low_mask((NUM_IRQ - (CFG_WORDS - 1) * 16) * 2);

	localparam logic [7:0]  CPU_BYTE  = 8'((1 << NUM_CPU) - 1);
	localparam logic [31:0] TGT_KEEP  = {4{CPU_BYTE}};
	localparam logic [31:0] TYPE_WORD = {24'd0, 3'(NUM_CPU - 1), 5'(BIT_WORDS - 1)};

	localparam logic [31:0] TGT_FIRST_WORD = 32'd8;

	req_t        req_q;
	logic        fwd_en_q;
	logic [31:0] enable_q  [BIT_WORDS];
	logic [31:0] pending_q [BIT_WORDS];
	logic [31:0] active_q  [BIT_WORDS];
	logic [31:0] trig_q    [CFG_WORDS];
	logic [31:0] prio_mem  [BYTE_DEPTH];
	logic [31:0] tgt_mem   [BYTE_DEPTH];
	logic [BYTE_DEPTH-1:0] prio_vld_q;
	logic [BYTE_DEPTH-1:0] tgt_vld_q;
	logic [31:0] prio_rd_q;
	logic [31:0] tgt_rd_q;
	logic        prio_rd_vld_q;
	logic        tgt_rd_vld_q;
	rsp_t        rsp_q;

	logic               wr;
	logic [3:0]         bank;
	logic [31:0]        idx32;
	logic [31:0]        data;
	logic [BIT_AW-1:0]  bit_a;
	logic [BYTE_AW-1:0] byte_a;
	logic [CFG_AW-1:0]  cfg_a;
	logic               err;
	logic               is_bits;
	logic               do_write;
	logic [31:0]        bit_live;
	logic [31:0]        byte_live;
	logic [31:0]        cfg_live;
	logic [31:0]        bit_word;
	logic [31:0]        bit_m;
	logic [31:0]        rd;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
	end

	always_comb begin
		wr     = (req_q.operation == OP_WRITE);
		bank   = req_q.register_bank;
		idx32  = {26'd0, req_q.register_index};
		data   = req_q.write_data;
		bit_a  = req_q.register_index[BIT_AW-1:0];
		byte_a = req_q.register_index[BYTE_AW-1:0];
		cfg_a  = req_q.register_index[CFG_AW-1:0];

		bit_live  = (idx32 == BIT_WORDS - 1)  ? BIT_LAST_MASK  : '1;
		byte_live = (idx32 == BYTE_WORDS - 1) ? BYTE_LAST_MASK : '1;
		cfg_live  = (idx32 == CFG_WORDS - 1)  ? CFG_LAST_MASK  : '1;
		bit_m     = data & bit_live;

		is_bits = 1'b0;
		case (bank)
			BANK_CTRL, BANK_TYPE: begin
				err = (idx32 != 32'd0);
			end
			BANK_SET_ENABLE, BANK_CLR_ENABLE, BANK_SET_PEND, BANK_CLR_PEND,
			BANK_SET_ACTIVE, BANK_CLR_ACTIVE: begin
				is_bits = 1'b1;
				err     = (idx32 >= BIT_WORDS);
			end
			BANK_PRIORITY, BANK_TARGETS: begin
				err = (idx32 >= BYTE_WORDS);
			end
			BANK_TRIGGER: begin
				err = (idx32 >= CFG_WORDS);
			end
			default: begin
				err = 1'b1;
			end
		endcase

		do_write = cmd.access && wr && !err;

		case (bank)
			BANK_SET_ENABLE, BANK_CLR_ENABLE: bit_word = enable_q[bit_a];
			BANK_SET_PEND, BANK_CLR_PEND:     bit_word = pending_q[bit_a];
			default:                          bit_word = active_q[bit_a];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_en_q   <= 1'b0;
			prio_vld_q <= '0;
			tgt_vld_q  <= '0;
			for (int i = 0; i < BIT_WORDS; i++) begin
				enable_q[i]  <= '0;
				pending_q[i] <= '0;
				active_q[i]  <= '0;
			end
			for (int i = 0; i < CFG_WORDS; i++) begin
				trig_q[i] <= '0;
			end
		end else if (do_write) begin
			case (bank)
				BANK_CTRL: begin
					fwd_en_q <= data[0];
				end
				BANK_SET_ENABLE: enable_q[bit_a]  <= enable_q[bit_a] | bit_m;
				BANK_CLR_ENABLE: enable_q[bit_a]  <= enable_q[bit_a] & ~bit_m;
				BANK_SET_PEND:   pending_q[bit_a] <= pending_q[bit_a] | bit_m;
				BANK_CLR_PEND:   pending_q[bit_a] <= pending_q[bit_a] & ~bit_m;
				BANK_SET_ACTIVE: active_q[bit_a]  <= active_q[bit_a] | bit_m;
				BANK_CLR_ACTIVE: active_q[bit_a]  <= active_q[bit_a] & ~bit_m;
				BANK_PRIORITY: begin
					prio_vld_q[byte_a] <= 1'b1;
				end
				BANK_TARGETS: begin
					if (idx32 >= TGT_FIRST_WORD) begin
						tgt_vld_q[byte_a] <= 1'b1;
					end
				end
				BANK_TRIGGER: begin
					if (idx32 != 32'd0) begin
						trig_q[cfg_a] <= data & EDGE_PATTERN & cfg_live;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_write && bank == BANK_PRIORITY) begin
			prio_mem[byte_a] <= data & byte_live;
		end
		if (cmd.access) begin
			prio_rd_q     <= prio_mem[byte_a];
			prio_rd_vld_q <= prio_vld_q[byte_a];
		end
	end

	always_ff @(posedge clk) begin
		if (do_write && bank == BANK_TARGETS && idx32 >= TGT_FIRST_WORD) begin
			tgt_mem[byte_a] <= data & TGT_KEEP & byte_live;
		end
		if (cmd.access) begin
			tgt_rd_q     <= tgt_mem[byte_a];
			tgt_rd_vld_q <= tgt_vld_q[byte_a];
		end
	end

	always_comb begin
		case (bank)
			BANK_CTRL: begin
				rd = {31'd0, fwd_en_q};
			end
			BANK_PRIORITY: begin
				rd = prio_rd_vld_q ? prio_rd_q : '0;
			end
			BANK_TARGETS: begin
				rd = (idx32 >= TGT_FIRST_WORD && tgt_rd_vld_q) ? tgt_rd_q : '0;
			end
			BANK_TRIGGER: begin
				rd = (idx32 == 32'd0) ? EDGE_PATTERN : trig_q[cfg_a];
			end
			BANK_TYPE: begin
				rd = TYPE_WORD;
			end
			default: begin
				rd = is_bits ? bit_word : '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q.read_data    <= (err || wr) ? 32'd0 : rd;
			rsp_q.access_error <= err;
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

// ----- hw/rtl/interrupt_distributor_register_bank.sv -----
// One request at a time: req_ready is high only in idle, so a new request is taken only after
// capture, access with its registered read of the priority or target store, and the result
// register, the three-step sequence, are through for the last one. A result held by rsp_ready
// low holds the sequence in its last step.
// Reset (arst_n low, asynchronous): clears the sequencer, forward enable, the bit
// banks, the trigger words and the valid bits of the priority and target stores.
`default_nettype none

module interrupt_distributor_register_bank
	import idb_pkg::*;
#(
	parameter int unsigned NUM_IRQ = 256,
	parameter int unsigned NUM_CPU = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	idb_cmd_t cmd;

	idb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	idb_datapath #(
		.NUM_IRQ (NUM_IRQ),
		.NUM_CPU (NUM_CPU)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// ----- tb/idb_access_checker.sv -----
module idb_access_checker
	import idb_pkg::*;
#(
	parameter int unsigned NUM_IRQ = 256,
	parameter int unsigned NUM_CPU = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   mismatches,
	output int   replies_due,
	output int   replies_checked
);

	localparam int unsigned BIT_WORDS      = (NUM_IRQ + 31) / 32;
	localparam int unsigned BYTE_WORDS     = (NUM_IRQ + 3) / 4;
	localparam int unsigned CFG_WORDS      = (NUM_IRQ + 15) / 16;
	localparam int unsigned FIRST_SPI_WORD = 32 / 4;
	localparam logic [31:0] CPU_BYTE       = ((32'd1 << NUM_CPU) - 32'd1) & 32'h0000_00FF;
	localparam logic [31:0] TYPE_WORD      = ((BIT_WORDS - 1) & 32'h1F) |
		(((NUM_CPU - 1) & 32'h7) << 5);

	logic        fwd_en;
	logic [31:0] en_bits   [BIT_WORDS];
	logic [31:0] pend_bits [BIT_WORDS];
	logic [31:0] act_bits  [BIT_WORDS];
	logic [31:0] prio_words[BYTE_WORDS];
	logic [31:0] tgt_words [BYTE_WORDS];
	logic [31:0] trig_words[CFG_WORDS];
	rsp_t        expected_replies[$];
	int          item_no;

	function automatic logic [31:0] live_lanes(int unsigned word, int unsigned per_word,
		int unsigned lane_bits);
		int unsigned first_irq;
		int unsigned left;
		first_irq = word * per_word;
		if (first_irq >= NUM_IRQ) return '0;
		left = NUM_IRQ - first_irq;
		if (left >= per_word) return '1;
		return (32'd1 << (left * lane_bits)) - 32'd1;
	endfunction

	function automatic logic [31:0] merge_bits(logic [31:0] old, logic [31:0] m, logic set);
		return set ? (old | m) : (old & ~m);
	endfunction

	task automatic predict_access(input req_t a, output rsp_t r);
		logic [31:0] rd;
		logic [31:0] m;
		logic [31:0] keep;
		logic        err;
		logic        wr;
		int unsigned idx;
		rd  = '0;
		err = 1'b0;
		wr  = (a.operation == OP_WRITE);
		idx = 32'(a.register_index);
		case (a.register_bank)
			BANK_CTRL: begin
				if (idx != 0) err = 1'b1;
				else begin
					if (wr) fwd_en = a.write_data[0];
					rd = {31'd0, fwd_en};
				end
			end
			BANK_SET_ENABLE, BANK_CLR_ENABLE, BANK_SET_PEND, BANK_CLR_PEND,
			BANK_SET_ACTIVE, BANK_CLR_ACTIVE: begin
				if (idx >= BIT_WORDS) err = 1'b1;
				else begin
					m = wr ? (a.write_data & live_lanes(idx, 32, 1)) : '0;
					case (a.register_bank)
						BANK_SET_ENABLE, BANK_CLR_ENABLE: begin
							en_bits[idx] = merge_bits(en_bits[idx], m, a.register_bank[0]);
							rd = en_bits[idx];
						end
						BANK_SET_PEND, BANK_CLR_PEND: begin
							pend_bits[idx] = merge_bits(pend_bits[idx], m, a.register_bank[0]);
							rd = pend_bits[idx];
						end
						default: begin
							act_bits[idx] = merge_bits(act_bits[idx], m, a.register_bank[0]);
							rd = act_bits[idx];
						end
					endcase
				end
			end
			BANK_PRIORITY: begin
				if (idx >= BYTE_WORDS) err = 1'b1;
				else begin
					if (wr) prio_words[idx] = a.write_data & live_lanes(idx, 4, 8);
					rd = prio_words[idx];
				end
			end
			BANK_TARGETS: begin
				if (idx >= BYTE_WORDS) err = 1'b1;
				else if (idx >= FIRST_SPI_WORD) begin
					keep = (CPU_BYTE * 32'h0101_0101) & live_lanes(idx, 4, 8);
					if (wr) tgt_words[idx] = a.write_data & keep;
					rd = tgt_words[idx];
				end
			end
			BANK_TRIGGER: begin
				if (idx >= CFG_WORDS) err = 1'b1;
				else begin
					if (wr && idx != 0)
						trig_words[idx] = a.write_data & EDGE_PATTERN & live_lanes(idx, 16, 2);
					rd = trig_words[idx];
				end
			end
			BANK_TYPE: begin
				if (idx != 0) err = 1'b1;
				else rd = TYPE_WORD;
			end
			default: err = 1'b1;
		endcase
		if (err || wr) rd = '0;
		r.read_data    = rd;
		r.access_error = err;
	endtask

	task automatic report_mismatch(string msg);
		$display("MISMATCH result %0d: %s", item_no, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t next_want;
		if (!arst_n) begin
			fwd_en = 1'b0;
			for (int i = 0; i < BIT_WORDS; i++) begin
				en_bits[i]   = '0;
				pend_bits[i] = '0;
				act_bits[i]  = '0;
			end
			for (int i = 0; i < BYTE_WORDS; i++) begin
				prio_words[i] = '0;
				tgt_words[i]  = '0;
			end
			for (int i = 0; i < CFG_WORDS; i++) trig_words[i] = '0;
			trig_words[0] = EDGE_PATTERN;
			expected_replies.delete();
			mismatches      = 0;
			replies_checked = 0;
			item_no         = 0;
			replies_due    <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				item_no++;
				if (expected_replies.size() == 0) begin
					report_mismatch($sformatf("unexpected item read_data=%h access_error=%b",
						rsp.read_data, rsp.access_error));
				end else begin
					want = expected_replies.pop_front();
					replies_checked++;
					if (rsp.read_data !== want.read_data)
						report_mismatch($sformatf("read_data %h, expected %h",
							rsp.read_data, want.read_data));
					if (rsp.access_error !== want.access_error)
						report_mismatch($sformatf("access_error %b, expected %b",
							rsp.access_error, want.access_error));
				end
			end
			if (req_valid && req_ready) begin
				predict_access(req, next_want);
				expected_replies.push_back(next_want);
			end
			replies_due <= expected_replies.size();
		end
	end

endmodule

// ----- tb/interrupt_distributor_register_bank_tb.sv -----
module interrupt_distributor_register_bank_tb;
	import idb_pkg::*;

	localparam int unsigned NUM_IRQ     = 256;
	localparam int unsigned NUM_CPU     = 8;
	localparam int unsigned BIT_WORDS   = (NUM_IRQ + 31) / 32;
	localparam int unsigned BYTE_WORDS  = (NUM_IRQ + 3) / 4;
	localparam int unsigned CFG_WORDS   = (NUM_IRQ + 15) / 16;
	localparam int          RANDOM_ITEMS = 500;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          TAIL_CYCLES  = 12;
	localparam int          CYCLE_LIMIT  = 200000;

	localparam logic [3:0] BANK_UNMAPPED_FIRST = 4'd11;
	localparam logic [3:0] BANK_UNMAPPED_LAST  = 4'd15;

	typedef enum int {READY_ALWAYS, READY_RANDOM, READY_SPARSE} ready_mode_e;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	int mismatches;
	int replies_due;
	int replies_checked;
	int cycle_count = 0;
	int items_sent  = 0;
	int burst_left  = 0;

	interrupt_distributor_register_bank #(
		.NUM_IRQ(NUM_IRQ),
		.NUM_CPU(NUM_CPU)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	idb_access_checker #(
		.NUM_IRQ(NUM_IRQ),
		.NUM_CPU(NUM_CPU)
	) u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.req            (req),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.rsp            (rsp),
		.mismatches     (mismatches),
		.replies_due    (replies_due),
		.replies_checked(replies_checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		rsp_ready = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("interrupt_distributor_register_bank test failed");
			$finish;
		end
	end

	// response side: segments of its own pattern, plus long hold-offs mid-run
	initial begin
		ready_mode_e mode;
		int          seg_left;
		int          hold_left;
		int          accepted;
		mode      = READY_ALWAYS;
		seg_left  = 0;
		hold_left = 0;
		accepted  = 0;
		forever begin
			@(posedge clk);
			if (req_valid && req_ready) begin
				accepted++;
				if (accepted == 150 || accepted == 380) hold_left = HOLD_CYCLES;
			end
			if (seg_left == 0) begin
				mode     = ready_mode_e'($urandom_range(0, 2));
				seg_left = $urandom_range(20, 200);
			end
			seg_left--;
			if (hold_left != 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				case (mode)
					READY_ALWAYS: rsp_ready <= 1'b1;
					READY_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
					default:      rsp_ready <= (seg_left % 4 == 0);
				endcase
			end
		end
	end

	function automatic req_t make_access(logic op, logic [3:0] bank, logic [5:0] idx,
		logic [31:0] data);
		req_t a;
		a.operation      = op;
		a.register_bank  = bank;
		a.register_index = idx;
		a.write_data     = data;
		return a;
	endfunction

	function automatic req_t random_access();
		req_t        a;
		int unsigned span;
		a.operation = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < 5)
			a.register_bank = 4'($urandom_range(BANK_UNMAPPED_FIRST, BANK_UNMAPPED_LAST));
		else
			a.register_bank = 4'($urandom_range(BANK_CTRL, BANK_TYPE));
		case (a.register_bank)
			BANK_CTRL, BANK_TYPE:           span = 1;
			BANK_PRIORITY, BANK_TARGETS:    span = (BYTE_WORDS > 64) ? 64 : BYTE_WORDS;
			BANK_TRIGGER:                   span = (CFG_WORDS > 64) ? 64 : CFG_WORDS;
			default:                        span = (BIT_WORDS > 64) ? 64 : BIT_WORDS;
		endcase
		if ($urandom_range(0, 9) == 0)
			a.register_index = 6'($urandom_range(0, 63));
		else if (span > 16 && $urandom_range(0, 1) == 0)
			a.register_index = 6'($urandom_range(6, 11));
		else
			a.register_index = 6'($urandom_range(0, span - 1));
		case ($urandom_range(0, 4))
			0:       a.write_data = '1;
			1:       a.write_data = 32'd1 << $urandom_range(0, 31);
			2:       a.write_data = $urandom & $urandom;
			3:       a.write_data = '0;
			default: a.write_data = $urandom;
		endcase
		return a;
	endfunction

	task automatic offer(input req_t a);
		int gap;
		req       <= a;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		items_sent++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (replies_due != 0) @(posedge clk);
	endtask

	initial begin
		int directed;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(make_access(OP_READ,  BANK_TYPE,       6'd0,  32'h0));
		offer(make_access(OP_WRITE, BANK_TYPE,       6'd0,  32'hFFFF_FFFF));
		offer(make_access(OP_READ,  BANK_TYPE,       6'd63, 32'h0));
		offer(make_access(OP_WRITE, BANK_CTRL,       6'd0,  32'hFFFF_FFFF));
		offer(make_access(OP_READ,  BANK_CTRL,       6'd0,  32'h5555_5555));
		offer(make_access(OP_WRITE, BANK_CTRL,       6'd1,  32'hFFFF_FFFF));
		offer(make_access(OP_WRITE, BANK_SET_ENABLE, 6'd7,  32'hFFFF_FFFF));
		offer(make_access(OP_WRITE, BANK_CLR_ENABLE, 6'd7,  32'h0000_FFFF));
		offer(make_access(OP_READ,  BANK_SET_ENABLE, 6'd7,  32'h0));
		offer(make_access(OP_WRITE, BANK_SET_PEND,   6'd0,  32'h8000_0001));
		offer(make_access(OP_READ,  BANK_CLR_PEND,   6'd0,  32'h0));
		offer(make_access(OP_READ,  BANK_CLR_PEND,   6'd8,  32'h0));
		offer(make_access(OP_WRITE, BANK_SET_ACTIVE, 6'd3,  32'hFFFF_FFFF));
		offer(make_access(OP_WRITE, BANK_CLR_ACTIVE, 6'd3,  32'hAAAA_AAAA));
		offer(make_access(OP_WRITE, BANK_PRIORITY,   6'd63, 32'hFFFF_FFFF));
		offer(make_access(OP_READ,  BANK_PRIORITY,   6'd63, 32'h0));
		offer(make_access(OP_WRITE, BANK_TARGETS,    6'd7,  32'hFFFF_FFFF));
		offer(make_access(OP_READ,  BANK_TARGETS,    6'd7,  32'h0));
		offer(make_access(OP_WRITE, BANK_TARGETS,    6'd8,  32'hFFFF_FFFF));
		offer(make_access(OP_READ,  BANK_TARGETS,    6'd8,  32'h0));
		offer(make_access(OP_WRITE, BANK_TRIGGER,    6'd0,  32'h0));
		offer(make_access(OP_READ,  BANK_TRIGGER,    6'd0,  32'h0));
		offer(make_access(OP_WRITE, BANK_TRIGGER,    6'd15, 32'hFFFF_FFFF));
		offer(make_access(OP_READ,  BANK_TRIGGER,    6'd15, 32'h0));
		offer(make_access(OP_READ,  BANK_TRIGGER,    6'd16, 32'h0));
		offer(make_access(OP_WRITE, BANK_UNMAPPED_FIRST, 6'd0, 32'hFFFF_FFFF));
		offer(make_access(OP_READ,  BANK_UNMAPPED_LAST,  6'd63, 32'h0));
		directed = items_sent;
		drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2) drain();
			offer(random_access());
		end
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d accesses sent (%0d directed), %0d results checked, %0d mismatches",
			items_sent, directed, replies_checked, mismatches);
		$display("covered all banks, out-of-range and unmapped accesses, stalls and drains");
		if (mismatches == 0)
			$display("interrupt_distributor_register_bank test passed");
		else
			$display("interrupt_distributor_register_bank test failed");
		$finish;
	end

endmodule

// ----- interrupt_distributor_register_bank.f -----
hw/rtl/idb_pkg.sv
hw/rtl/idb_ctrl.sv
hw/rtl/idb_datapath.sv
hw/rtl/interrupt_distributor_register_bank.sv
tb/idb_access_checker.sv
tb/interrupt_distributor_register_bank_tb.sv
